// File: hdl/dwt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and shaper tables of the waveshaper tone core.
package dwt_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int DRIVE_W    = 16;
    localparam int OGAIN_W    = 9;
    localparam int COEF_W     = 18;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int STATE_W    = 32;
    localparam int SHAPED_W   = 20;
    localparam int MAG_W      = 19;
    localparam int FRAC_W     = 19;

    // Shared multiplier: 33 x 20 signed, 53-bit product; accumulators 54 bits
    localparam int MUL_AW     = 33;
    localparam int MUL_BW     = 20;
    localparam int MUL_PW     = MUL_AW + MUL_BW;
    localparam int ACC_W      = 54;

    // Shaper tables: N+1 points over [0,16], Q.30 values
    localparam int SHAPER_TABLE_ENTRIES = 256;
    localparam int TAB_AW     = $clog2(SHAPER_TABLE_ENTRIES);
    localparam int TAB_IW     = TAB_AW + 1;
    localparam int TAB_DW     = 31;

    localparam logic [63:0] ONE30    = 64'd1 << 30;
    localparam logic [63:0] HALF30   = 64'd1 << 29;
    localparam logic [63:0] EXP_STEP = (64'd16 << 30) / SHAPER_TABLE_ENTRIES;
    localparam int          TAYLOR_TERMS = 12;

    // Register reset values
    localparam logic [DRIVE_W-1:0]        DRIVE_RST = 16'd24576;
    localparam logic [OGAIN_W-1:0]        OGAIN_RST = 9'd128;
    localparam logic signed [COEF_W-1:0]  B0_RST    = 18'sd65536;

    typedef enum logic [1:0] {
        MODE_SOFT = 2'd0,
        MODE_HARD = 2'd1,
        MODE_FUZZ = 2'd2,
        MODE_PASS = 2'd3
    } shape_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIVE_GAIN  = 3'd0,
        REG_SHAPE_MODE  = 3'd1,
        REG_OUTPUT_GAIN = 3'd2,
        REG_COEF_B0     = 3'd3,
        REG_COEF_B1     = 3'd4,
        REG_COEF_B2     = 3'd5,
        REG_COEF_A1     = 3'd6,
        REG_COEF_A2     = 3'd7
    } cfg_reg_t;

    typedef logic [TAB_DW-1:0] shaper_tab_t [SHAPER_TABLE_ENTRIES+1];

    // Restoring long division, used only while building the tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-16/N) by a truncated Taylor sum in Q.30
    function automatic logic [63:0] exp_ratio();
        logic [63:0] sum;
        logic [63:0] term;
        sum  = ONE30;
        term = ONE30;
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = udiv64((term * EXP_STEP) >> 30, 64'(k));
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic shaper_tab_t build_exp_tab();
        shaper_tab_t tab;
        logic [63:0] r;
        logic [63:0] e;
        r = exp_ratio();
        e = ONE30;
        for (int i = 0; i <= SHAPER_TABLE_ENTRIES; i++)
        begin
            if (i > 0)
                e = (e * r + HALF30) >> 30;
            tab[i] = TAB_DW'(e);
        end
        return tab;
    endfunction

    // tanh(x) = (1 - e^-2x) / (1 + e^-2x)
    function automatic shaper_tab_t build_tanh_tab();
        shaper_tab_t tab;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] q;
        r = exp_ratio();
        e = ONE30;
        for (int i = 0; i <= SHAPER_TABLE_ENTRIES; i++)
        begin
            if (i > 0)
                e = (e * r + HALF30) >> 30;
            q      = (e * e + HALF30) >> 30;
            tab[i] = TAB_DW'(udiv64((ONE30 - q) << 30, ONE30 + q));
        end
        return tab;
    endfunction

    localparam shaper_tab_t EXP_TAB  = build_exp_tab();
    localparam shaper_tab_t TANH_TAB = build_tanh_tab();

endpackage

// File: hdl/dwt_if.sv
`timescale 1ns / 1ps
// Valid/ready sample channels of the waveshaper tone core.
interface dwt_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dwt_pkg::SAMPLE_W-1:0]    sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface dwt_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dwt_pkg::SAMPLE_W-1:0]    sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// File: hdl/dwt_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
module dwt_mul (
    input  logic                                clk,
    input  logic signed [dwt_pkg::MUL_AW-1:0]   a,
    input  logic signed [dwt_pkg::MUL_BW-1:0]   b,
    output logic signed [dwt_pkg::MUL_PW-1:0]   p_reg
);

    // One product per cycle, ready for the sequencer on the next state
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

// File: hdl/distortion_waveshaper_tone_core.sv
`timescale 1ns / 1ps
// Waveshaping distortion with biquad low-pass tone stage, top level.
//
// The tanh and fuzz modes run the interpolation and shaping steps that hard
// clip and pass-through modes skip. A single 33x20 signed multiplier is shared
// over the drive gain, table interpolation, the five biquad products and the
// output gain; a sequencer steps it at most one product per cycle and holds in
// the output step while a finished result is blocked. While a sample is in work
// the input is not ready; a finished sample waits in the output register and a
// new sample can be taken meanwhile. The filter state survives from sample to
// sample and is cleared only by reset. Configuration is written through a
// plain write port (write enable, index 0..7, 18-bit data); the user must
// write it only while idle; the block itself does not enforce this.
module distortion_waveshaper_tone_core (
    input  logic                                clk,
    input  logic                                rst_n,
    dwt_in_if.sink                              in_chan,
    dwt_out_if.source                           out_chan,
    input  logic                                cfg_we,
    input  logic [dwt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dwt_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int AW  = dwt_pkg::MUL_AW;
    localparam int BW  = dwt_pkg::MUL_BW;
    localparam int PW  = dwt_pkg::MUL_PW;
    localparam int CW  = dwt_pkg::ACC_W;
    localparam int SW  = dwt_pkg::SHAPED_W;
    localparam int ZW  = dwt_pkg::STATE_W;

    localparam logic signed [CW-1:0] ROUND16  = CW'(32768);
    localparam logic signed [CW-1:0] ROUND8   = CW'(128);
    localparam logic signed [CW-1:0] MAX32    = CW'(64'sd2147483647);
    localparam logic signed [CW-1:0] MIN32    = -CW'(64'sd2147483648);
    localparam logic signed [CW-1:0] MAX16    = CW'(32767);
    localparam logic signed [CW-1:0] MIN16    = -CW'(32768);
    localparam logic signed [SW-1:0] CLIP_POS = SW'(32768);
    localparam logic signed [SW-1:0] CLIP_NEG = -SW'(32768);
    localparam logic signed [AW-1:0] ONE30_S  = AW'(dwt_pkg::ONE30);
    localparam logic signed [AW-1:0] HALF15_S = AW'(16384);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_DRIVE  = 12'b0000_0000_0010,
        ST_TAB    = 12'b0000_0000_0100,
        ST_INTERP = 12'b0000_0000_1000,
        ST_SHAPE  = 12'b0000_0001_0000,
        ST_B0     = 12'b0000_0010_0000,
        ST_Y      = 12'b0000_0100_0000,
        ST_A1     = 12'b0000_1000_0000,
        ST_Z1     = 12'b0001_0000_0000,
        ST_A2     = 12'b0010_0000_0000,
        ST_Z2     = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } state_t;

    // Saturation helpers
    function automatic logic signed [ZW-1:0] sat32(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] c;
        c = (v > MAX32) ? MAX32 : ((v < MIN32) ? MIN32 : v);
        return c[ZW-1:0];
    endfunction

    function automatic logic signed [dwt_pkg::SAMPLE_W-1:0] sat16(
        input logic signed [CW-1:0] v);
        logic signed [CW-1:0] c;
        c = (v > MAX16) ? MAX16 : ((v < MIN16) ? MIN16 : v);
        return c[dwt_pkg::SAMPLE_W-1:0];
    endfunction

    // Configuration registers
    logic [dwt_pkg::DRIVE_W-1:0]            drive_gain_reg;
    dwt_pkg::shape_mode_t                   mode_reg;
    logic [dwt_pkg::OGAIN_W-1:0]            out_gain_reg;
    logic signed [dwt_pkg::COEF_W-1:0]      b0_reg;
    logic signed [dwt_pkg::COEF_W-1:0]      b1_reg;
    logic signed [dwt_pkg::COEF_W-1:0]      b2_reg;
    logic signed [dwt_pkg::COEF_W-1:0]      a1_reg;
    logic signed [dwt_pkg::COEF_W-1:0]      a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_gain_reg <= dwt_pkg::DRIVE_RST;
            mode_reg       <= dwt_pkg::MODE_SOFT;
            out_gain_reg   <= dwt_pkg::OGAIN_RST;
            b0_reg         <= dwt_pkg::B0_RST;
            b1_reg         <= '0;
            b2_reg         <= '0;
            a1_reg         <= '0;
            a2_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (dwt_pkg::cfg_reg_t'(cfg_index))
                dwt_pkg::REG_DRIVE_GAIN:  drive_gain_reg <= cfg_wdata[dwt_pkg::DRIVE_W-1:0];
                dwt_pkg::REG_SHAPE_MODE:  mode_reg <= dwt_pkg::shape_mode_t'(cfg_wdata[1:0]);
                dwt_pkg::REG_OUTPUT_GAIN: out_gain_reg <= cfg_wdata[dwt_pkg::OGAIN_W-1:0];
                dwt_pkg::REG_COEF_B0:     b0_reg <= $signed(cfg_wdata);
                dwt_pkg::REG_COEF_B1:     b1_reg <= $signed(cfg_wdata);
                dwt_pkg::REG_COEF_B2:     b2_reg <= $signed(cfg_wdata);
                dwt_pkg::REG_COEF_A1:     a1_reg <= $signed(cfg_wdata);
                dwt_pkg::REG_COEF_A2:     a2_reg <= $signed(cfg_wdata);
            endcase
        end
    end

    // Sequencer and datapath registers
    state_t                                 state_reg;
    state_t                                 state_next;
    logic signed [dwt_pkg::SAMPLE_W-1:0]    x_reg;
    logic [dwt_pkg::TAB_DW-1:0]             t0_reg;
    logic signed [ZW-1:0]                   diff_reg;
    logic [dwt_pkg::FRAC_W-1:0]             frac_reg;
    logic                                   neg_reg;
    logic signed [SW-1:0]                   s_reg;
    logic signed [ZW-1:0]                   y_reg;
    logic signed [CW-1:0]                   acc_reg;
    logic signed [ZW-1:0]                   z1_reg;
    logic signed [ZW-1:0]                   z2_reg;
    logic                                   out_valid_reg;
    logic signed [dwt_pkg::SAMPLE_W-1:0]    out_sample_reg;

    logic signed [AW-1:0]                   mul_a;
    logic signed [BW-1:0]                   mul_b;
    logic signed [PW-1:0]                   prod_reg;
    logic signed [CW-1:0]                   prod_ext;

    logic                                   in_xfer;
    logic                                   out_load;

    assign in_xfer  = in_chan.valid && in_chan.ready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_chan.ready);
    assign prod_ext = CW'(prod_reg);

    // Drive-scaled sample, magnitude and table address
    logic signed [PW-1:0]                   g_full;
    logic signed [SW-1:0]                   g;
    logic                                   g_neg;
    logic signed [SW-1:0]                   g_abs;
    logic [dwt_pkg::MAG_W-1:0]              mag;
    logic [dwt_pkg::TAB_AW-1:0]             tab_idx;
    logic [dwt_pkg::TAB_IW-1:0]             idx_lo;
    logic [dwt_pkg::TAB_IW-1:0]             idx_hi;
    logic [dwt_pkg::FRAC_W-1:0]             frac;
    logic [dwt_pkg::TAB_DW-1:0]             tab_lo;
    logic [dwt_pkg::TAB_DW-1:0]             tab_hi;
    logic signed [SW-1:0]                   g_clip;

    assign g_full  = prod_reg >>> 12;
    assign g       = g_full[SW-1:0];
    assign g_neg   = g[SW-1];
    assign g_abs   = g_neg ? -g : g;
    assign mag     = g_abs[dwt_pkg::MAG_W-1:0];
    assign tab_idx = dwt_pkg::TAB_AW'(mag >> (dwt_pkg::MAG_W - dwt_pkg::TAB_AW));
    assign idx_lo  = {1'b0, tab_idx};
    assign idx_hi  = idx_lo + 1'b1;
    assign frac    = mag << dwt_pkg::TAB_AW;
    assign tab_lo  = (mode_reg == dwt_pkg::MODE_FUZZ) ? dwt_pkg::EXP_TAB[idx_lo]
                                                      : dwt_pkg::TANH_TAB[idx_lo];
    assign tab_hi  = (mode_reg == dwt_pkg::MODE_FUZZ) ? dwt_pkg::EXP_TAB[idx_hi]
                                                      : dwt_pkg::TANH_TAB[idx_hi];
    assign g_clip  = (g > CLIP_POS) ? CLIP_POS : ((g < CLIP_NEG) ? CLIP_NEG : g);

    // Interpolated table value and rounded shaper output
    logic signed [PW-1:0]                   interp_full;
    logic signed [AW-1:0]                   tab_v;
    logic signed [AW-1:0]                   shaped_w;
    logic signed [AW-1:0]                   shaped_r;
    logic signed [SW-1:0]                   shaped_mag;

    assign interp_full = prod_reg >>> dwt_pkg::FRAC_W;
    assign tab_v       = $signed({2'b00, t0_reg}) + interp_full[AW-1:0];
    assign shaped_w    = (mode_reg == dwt_pkg::MODE_FUZZ) ? (ONE30_S - tab_v) : tab_v;
    assign shaped_r    = (shaped_w + HALF15_S) >>> 15;
    assign shaped_mag  = shaped_r[SW-1:0];

    // Biquad sums
    logic signed [CW-1:0]                   y_sum;
    logic signed [CW-1:0]                   z_sum;
    logic signed [CW-1:0]                   out_sum;

    assign y_sum   = (prod_ext + (CW'(z1_reg) <<< 16) + ROUND16) >>> 16;
    assign z_sum   = (acc_reg - prod_ext + ROUND16) >>> 16;
    assign out_sum = (prod_ext + ROUND8) >>> 8;

    // Multiplier operand select; the output gain product is held while the result waits
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DRIVE:
            begin
                mul_a = $signed({{(AW-dwt_pkg::DRIVE_W){1'b0}}, drive_gain_reg});
                mul_b = BW'(x_reg);
            end
            ST_INTERP:
            begin
                mul_a = AW'(diff_reg);
                mul_b = $signed({1'b0, frac_reg});
            end
            ST_B0:
            begin
                mul_a = AW'(b0_reg);
                mul_b = s_reg;
            end
            ST_Y:
            begin
                mul_a = AW'(b1_reg);
                mul_b = s_reg;
            end
            ST_A1:
            begin
                mul_a = AW'(y_reg);
                mul_b = BW'(a1_reg);
            end
            ST_Z1:
            begin
                mul_a = AW'(b2_reg);
                mul_b = s_reg;
            end
            ST_A2:
            begin
                mul_a = AW'(y_reg);
                mul_b = BW'(a2_reg);
            end
            ST_Z2, ST_OUT:
            begin
                mul_a = AW'(y_reg);
                mul_b = $signed({{(BW-dwt_pkg::OGAIN_W){1'b0}}, out_gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dwt_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod_reg)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = in_xfer ? ST_DRIVE : ST_IDLE;
            ST_DRIVE:  state_next = ST_TAB;
            ST_TAB:
            begin
                if (mode_reg == dwt_pkg::MODE_SOFT || mode_reg == dwt_pkg::MODE_FUZZ)
                    state_next = ST_INTERP;
                else
                    state_next = ST_B0;
            end
            ST_INTERP: state_next = ST_SHAPE;
            ST_SHAPE:  state_next = ST_B0;
            ST_B0:     state_next = ST_Y;
            ST_Y:      state_next = ST_A1;
            ST_A1:     state_next = ST_Z1;
            ST_Z1:     state_next = ST_A2;
            ST_A2:     state_next = ST_Z2;
            ST_Z2:     state_next = ST_OUT;
            ST_OUT:    state_next = out_load ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            z1_reg        <= '0;
            z2_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_chan.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_Z1)
                z1_reg <= sat32(z_sum);
            if (state_reg == ST_Z2)
                z2_reg <= sat32(z_sum);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            x_reg <= in_chan.sample_in;
        if (state_reg == ST_TAB)
        begin
            t0_reg   <= tab_lo;
            diff_reg <= $signed({1'b0, tab_hi}) - $signed({1'b0, tab_lo});
            frac_reg <= frac;
            neg_reg  <= g_neg;
            s_reg    <= (mode_reg == dwt_pkg::MODE_HARD) ? g_clip : g;
        end
        if (state_reg == ST_SHAPE)
            s_reg <= neg_reg ? -shaped_mag : shaped_mag;
        if (state_reg == ST_Y)
            y_reg <= sat32(y_sum);
        if (state_reg == ST_A1)
            acc_reg <= prod_ext + (CW'(z2_reg) <<< 16);
        if (state_reg == ST_A2)
            acc_reg <= prod_ext;
        if (out_load)
            out_sample_reg <= sat16(out_sum);
    end

    assign in_chan.ready       = (state_reg == ST_IDLE);
    assign out_chan.valid      = out_valid_reg;
    assign out_chan.sample_out = out_sample_reg;

    // Checks
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output valid raised outside the output step");

    a_out_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && !out_chan.ready) |=> state_reg == ST_OUT)
        else $error("sequencer left the output step while the result was blocked");

    a_shaped_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg == ST_SHAPE)
            || $past(state_reg == ST_TAB && mode_reg == dwt_pkg::MODE_HARD))
        |-> (s_reg <= CLIP_POS && s_reg >= CLIP_NEG))
        else $error("shaped sample outside plus or minus one");

endmodule

// File: bench/distortion_waveshaper_tone_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the waveshaper tone core: shaping modes, biquad state, gains.
module distortion_waveshaper_tone_core_tb;
    import dwt_pkg::*;

    localparam int LUT_N      = SHAPER_TABLE_ENTRIES;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 130;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 16;

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;
    localparam longint S32_MAX = 64'sh7FFF_FFFF;
    localparam longint S32_MIN = -64'sh8000_0000;

    // Coefficient corners and a gentle low-pass set, Q2.16
    localparam logic [COEF_W-1:0] COEF_MIN  = 18'h20000;
    localparam logic [COEF_W-1:0] COEF_MAX  = 18'h1FFFF;
    localparam logic [COEF_W-1:0] COEF_UNIT = 18'h10000;
    localparam logic [COEF_W-1:0] LP_B0     = 18'sd1318;
    localparam logic [COEF_W-1:0] LP_B1     = 18'sd2636;
    localparam logic [COEF_W-1:0] LP_A1     = -18'sd102300;
    localparam logic [COEF_W-1:0] LP_A2     = 18'sd42036;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Stimulus-side drive registers
    logic                        drv_valid = 1'b0;
    logic signed [SAMPLE_W-1:0]  drv_sample = '0;
    logic                        mon_ready = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]            cfg_wdata = '0;

    dwt_in_if  in_chan();
    dwt_out_if out_chan();

    assign in_chan.valid     = drv_valid;
    assign in_chan.sample_in = drv_sample;
    assign out_chan.ready    = mon_ready;

    distortion_waveshaper_tone_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_chan),
        .out_chan  (out_chan),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Shadow copy of the registers and filter state
    logic [DRIVE_W-1:0]  tone_drive = DRIVE_RST;
    shape_mode_t         tone_mode  = MODE_SOFT;
    logic [OGAIN_W-1:0]  tone_ogain = OGAIN_RST;
    longint              tone_b0 = 65536;
    longint              tone_b1 = 0;
    longint              tone_b2 = 0;
    longint              tone_a1 = 0;
    longint              tone_a2 = 0;
    longint              delay_z1 = 0;
    longint              delay_z2 = 0;

    longint unsigned     exp_lut  [0:LUT_N];
    longint unsigned     tanh_lut [0:LUT_N];

    logic signed [SAMPLE_W-1:0] pending_samples[$];
    logic signed [SAMPLE_W-1:0] expected_outputs[$];
    logic signed [SAMPLE_W-1:0] want_sample;

    bit gaps_on = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_at = 300;
    int long_holds = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int settings_loaded = 0;
    int error_count = 0;

    // exp(-x) and tanh(x) tables on 16*i/N, Q.30
    task automatic build_shaper_luts();
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] e;
        logic [63:0] q;
        step  = (64'd16 << 30) / LUT_N;
        ratio = Q30_ONE;
        term  = Q30_ONE;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * step) >> 30) / 64'(k);
            if (k % 2 == 1)
                ratio = ratio - term;
            else
                ratio = ratio + term;
        end
        e = Q30_ONE;
        for (int i = 0; i <= LUT_N; i++)
        begin
            if (i > 0)
                e = (e * ratio + Q30_HALF) >> 30;
            exp_lut[i]  = e;
            q           = (e * e + Q30_HALF) >> 30;
            tanh_lut[i] = ((Q30_ONE - q) << 30) / (Q30_ONE + q);
        end
    endtask

    function automatic longint unsigned lut_interp(input bit use_exp, input longint unsigned mag);
        longint unsigned p;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned lo;
        longint unsigned hi;
        p    = mag * LUT_N;
        idx  = p >> 19;
        frac = p & 64'h7FFFF;
        if (idx >= LUT_N)
            return use_exp ? exp_lut[LUT_N] : tanh_lut[LUT_N];
        lo = use_exp ? exp_lut[idx] : tanh_lut[idx];
        hi = use_exp ? exp_lut[idx + 1] : tanh_lut[idx + 1];
        return (lo * ((64'd1 << 19) - frac) + hi * frac) >> 19;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    // Drive, shape, filter and scale one sample; advances the filter state
    function automatic logic signed [SAMPLE_W-1:0] predict_tone_sample(
        input logic signed [SAMPLE_W-1:0] x);
        longint gained;
        longint shaped;
        longint acc_y;
        longint nz1;
        longint nz2;
        longint scaled;
        longint unsigned mag;
        gained = (longint'(x) * longint'(tone_drive)) >>> 12;
        mag    = (gained < 0) ? -gained : gained;
        case (tone_mode)
            MODE_SOFT:
            begin
                shaped = (lut_interp(1'b0, mag) + 16384) >> 15;
                if (gained < 0)
                    shaped = -shaped;
            end
            MODE_HARD:
                shaped = clamp_to(gained, -32768, 32768);
            MODE_FUZZ:
            begin
                shaped = (Q30_ONE - lut_interp(1'b1, mag) + 16384) >> 15;
                if (gained < 0)
                    shaped = -shaped;
            end
            default:
                shaped = gained;
        endcase
        acc_y = clamp_to(round_q16(tone_b0 * shaped + delay_z1 * 65536), S32_MIN, S32_MAX);
        nz1   = clamp_to(round_q16(tone_b1 * shaped - tone_a1 * acc_y + delay_z2 * 65536),
                         S32_MIN, S32_MAX);
        nz2   = clamp_to(round_q16(tone_b2 * shaped - tone_a2 * acc_y), S32_MIN, S32_MAX);
        delay_z1 = nz1;
        delay_z2 = nz2;
        scaled = clamp_to((acc_y * longint'(tone_ogain) + 128) >>> 8, -32768, 32767);
        return 16'(scaled);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 4);
        if (roll < 96)
            return $urandom_range(5, 16);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 16'($urandom);
        if (roll < 8)
            return 16'(int'($urandom_range(0, 4000)) - 2000);
        if (roll == 8)
            return 16'(32767 - int'($urandom_range(0, 63)));
        return 16'(-32768 + int'($urandom_range(0, 63)));
    endfunction

    // One register write, mirrored into the shadow copy
    task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_DRIVE_GAIN:  tone_drive = data[DRIVE_W-1:0];
            REG_SHAPE_MODE:  tone_mode  = shape_mode_t'(data[1:0]);
            REG_OUTPUT_GAIN: tone_ogain = data[OGAIN_W-1:0];
            REG_COEF_B0:     tone_b0 = longint'($signed(data[COEF_W-1:0]));
            REG_COEF_B1:     tone_b1 = longint'($signed(data[COEF_W-1:0]));
            REG_COEF_B2:     tone_b2 = longint'($signed(data[COEF_W-1:0]));
            REG_COEF_A1:     tone_a1 = longint'($signed(data[COEF_W-1:0]));
            default:         tone_a2 = longint'($signed(data[COEF_W-1:0]));
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Full register set; unused upper data bits carry junk
    task automatic load_setting(input logic [DRIVE_W-1:0] drive, input shape_mode_t mode,
                                input logic [OGAIN_W-1:0] ogain,
                                input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                                input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                                input logic [COEF_W-1:0] a2);
        logic [CFG_W-1:0] junk;
        junk = 18'($urandom);
        write_cfg(REG_DRIVE_GAIN, {junk[17:16], drive});
        write_cfg(REG_SHAPE_MODE, {junk[17:2], mode});
        write_cfg(REG_OUTPUT_GAIN, {junk[17:9], ogain});
        write_cfg(REG_COEF_B0, b0);
        write_cfg(REG_COEF_B1, b1);
        write_cfg(REG_COEF_B2, b2);
        write_cfg(REG_COEF_A1, a1);
        write_cfg(REG_COEF_A2, a2);
        settings_loaded++;
    endtask

    // Append one sample to the stimulus queue
    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] smp);
        pending_samples.insert(pending_samples.size(), smp);
    endtask

    // Hold off until every issued sample has come back, then let the sequencer settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || drv_valid || expected_outputs.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Input driver: one transfer per handshake, random gaps between items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid  <= 1'b0;
            drv_sample <= '0;
            send_gap = 0;
        end
        else
        begin
            if (drv_valid && in_chan.ready)
            begin
                expected_outputs.insert(expected_outputs.size(),
                                        predict_tone_sample(drv_sample));
                samples_sent++;
            end
            if (!drv_valid || in_chan.ready)
            begin
                if (send_gap > 0)
                begin
                    drv_valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_samples.size() > 0)
                begin
                    drv_valid  <= 1'b1;
                    drv_sample <= pending_samples.pop_front();
                    send_gap = pick_gap();
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each transfer, stalls at random, two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_chan.valid && mon_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    $display("%0t: unexpected sample_out, expected none, actual %0d",
                             $time, out_chan.sample_out);
                    error_count++;
                end
                else
                begin
                    want_sample = expected_outputs.pop_front();
                    if (out_chan.sample_out !== want_sample)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, want_sample, out_chan.sample_out);
                        error_count++;
                    end
                end
                results_seen++;
                if (long_holds < 2 && results_seen == hold_at)
                begin
                    hold_left = HOLD_LEN;
                    hold_at   = hold_at + 450;
                    long_holds++;
                end
            end
            if (hold_left > 0)
            begin
                mon_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                mon_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                mon_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Sequence: reset, directed corners per mode, over-range run, then register phases
    initial
    begin
        logic signed [SAMPLE_W-1:0] corner_vals [5];
        shape_mode_t                mode_list [4];
        logic [DRIVE_W-1:0]         rnd_drive;
        logic [OGAIN_W-1:0]         rnd_ogain;
        shape_mode_t                rnd_mode;
        corner_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF};
        mode_list   = '{MODE_SOFT, MODE_HARD, MODE_FUZZ, MODE_PASS};
        build_shaper_luts();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Corners in each mode; the first pass runs on the reset register values
        foreach (mode_list[m])
        begin
            if (m > 0)
                write_cfg(REG_SHAPE_MODE, {16'($urandom), mode_list[m]});
            foreach (corner_vals[i])
                queue_sample(corner_vals[i]);
            wait_drained();
        end

        // Over-range gains and a runaway filter that drives the output into saturation
        load_setting(16'hFFFF, MODE_PASS, 9'h1FF, COEF_MAX, 18'd0, 18'd0, COEF_MIN, 18'd0);
        repeat (5) queue_sample(16'sh7FFF);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            gaps_on   = (phase != 2 && phase != 6);
            rnd_drive = 16'($urandom_range(4096, 45056));
            rnd_ogain = 9'($urandom_range(0, 256));
            rnd_mode  = shape_mode_t'($urandom_range(MODE_SOFT, MODE_PASS));
            case (phase)
                0: load_setting(16'd4096, MODE_SOFT, 9'd256, COEF_UNIT, 18'd0, 18'd0,
                                18'd0, 18'd0);
                1: load_setting(16'd45056, MODE_FUZZ, 9'd256, LP_B0, LP_B1, LP_B0,
                                LP_A1, LP_A2);
                2: load_setting(16'hFFFF, MODE_HARD, 9'h1FF, LP_B0, LP_B1, LP_B0,
                                LP_A1, LP_A2);
                3: load_setting(rnd_drive, MODE_PASS, 9'd0, COEF_MIN, COEF_MIN, COEF_MIN,
                                COEF_MIN, COEF_MIN);
                4: load_setting(rnd_drive, MODE_SOFT, rnd_ogain, LP_B0, LP_B1, LP_B0,
                                LP_A1, LP_A2);
                5: load_setting(rnd_drive, rnd_mode, 9'd256, COEF_MAX, COEF_MAX, COEF_MAX,
                                COEF_MAX, COEF_MAX);
                6: load_setting(rnd_drive, MODE_FUZZ, rnd_ogain,
                                18'(int'($urandom_range(0, 32767)) - 16384),
                                18'(int'($urandom_range(0, 32767)) - 16384),
                                18'(int'($urandom_range(0, 32767)) - 16384),
                                18'(int'($urandom_range(0, 32767)) - 16384),
                                18'(int'($urandom_range(0, 32767)) - 16384));
                default: load_setting(16'($urandom), rnd_mode, 9'($urandom),
                                      18'($urandom), 18'($urandom), 18'($urandom),
                                      18'($urandom), 18'($urandom));
            endcase
            repeat (PHASE_LEN) queue_sample(rand_sample());
            wait_drained();
        end

        $display("Ran %0d samples through all four shaping modes under %0d register sets,",
                 samples_sent, settings_loaded + 1);
        $display("with random gaps, two long output hold-offs; %0d results checked, %0d errors.",
                 results_seen, error_count);
        if (error_count == 0)
            $display("distortion_waveshaper_tone_core_tb: PASS");
        else
            $display("distortion_waveshaper_tone_core_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("Timeout with %0d results still outstanding", expected_outputs.size());
        $display("distortion_waveshaper_tone_core_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/dwt_pkg.sv
hdl/dwt_if.sv
hdl/dwt_mul.sv
hdl/distortion_waveshaper_tone_core.sv
bench/distortion_waveshaper_tone_core_tb.sv
